### rtl/kphr_pkg.sv
// Shared types and constants for the key press / hold / release event detector.
// Used by kphr_keytable, the top level and the port checker.
`timescale 1ns / 1ps

package kphr_pkg;

  // Number of keys tracked, and field widths.
  localparam int KEYS   = 16;
  localparam int KeyW   = 4;
  localparam int CountW = 8;
  localparam int KindW  = 2;

  // Event codes.
  typedef enum logic [KindW-1:0] {
    KIND_BEGIN = 2'd0,
    KIND_KEEP  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // One key sample as held in the input register.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            pressed;
    logic            stop;
  } key_req_t;

  // Event produced by one sample.
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    kind_e             kind;
    logic [CountW-1:0] ticks;
  } key_event_t;

endpackage

### rtl/kphr_keytable.sv
// Per-key state table (level, keep enable, hold counter) and event logic.
// Depends on kphr_pkg.
`timescale 1ns / 1ps

module kphr_keytable (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kphr_pkg::key_req_t    req_i,
  input  logic                  commit_i,
  output kphr_pkg::key_event_t  event_o
);
  import kphr_pkg::*;

  logic              level_q [KEYS];
  logic              keep_q  [KEYS];
  logic [CountW-1:0] count_q [KEYS];

  logic              hit;
  logic              cur_level;
  logic              cur_keep;
  logic [CountW-1:0] cur_count;
  logic [CountW-1:0] count_inc;
  logic              level_d;
  logic              keep_d;
  logic [CountW-1:0] count_d;
  logic              write_en;

  // Samples for keys beyond the table are dropped without effect.
  assign hit = (int'(req_i.key) < KEYS);

  // Read the addressed entry.
  always_comb begin
    cur_level = 1'b0;
    cur_keep  = 1'b0;
    cur_count = '0;
    if (hit) begin
      cur_level = level_q[req_i.key];
      cur_keep  = keep_q[req_i.key];
      cur_count = count_q[req_i.key];
    end
  end

  assign count_inc = cur_count + CountW'(1);

  // Edge detection, counter update and event selection.
  always_comb begin
    level_d       = cur_level;
    keep_d        = cur_keep;
    count_d       = cur_count;
    event_o.valid = 1'b0;
    event_o.key   = req_i.key;
    event_o.kind  = KIND_BEGIN;
    event_o.ticks = '0;
    if (hit) begin
      if (req_i.pressed != cur_level) begin
        level_d = req_i.pressed;
        if (req_i.pressed) begin
          count_d       = '0;
          keep_d        = ~req_i.stop;
          event_o.valid = 1'b1;
          event_o.kind  = KIND_BEGIN;
        end else begin
          // Release: stop is ignored and keep enable is left alone.
          count_d       = count_inc;
          event_o.valid = 1'b1;
          event_o.kind  = KIND_END;
          event_o.ticks = count_inc;
        end
      end else if (req_i.pressed) begin
        count_d = count_inc;
        if (cur_keep) begin
          event_o.valid = 1'b1;
          event_o.kind  = KIND_KEEP;
          event_o.ticks = count_inc;
          if (req_i.stop) begin
            keep_d = 1'b0;
          end
        end
      end
    end
  end

  assign write_en = commit_i & hit;

  // Write back the addressed entry when the sample leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYS; i++) begin
        level_q[i] <= 1'b0;
        keep_q[i]  <= 1'b0;
        count_q[i] <= '0;
      end
    end else if (write_en) begin
      level_q[req_i.key] <= level_d;
      keep_q[req_i.key]  <= keep_d;
      count_q[req_i.key] <= count_d;
    end
  end

endmodule

### rtl/key_press_hold_release_events_top.sv
// Top level of the key press / hold / release event detector.
// Depends on kphr_pkg and kphr_keytable.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o  | key_index_i, pressed_i, stop_keep_i
//   out     | out_valid_o / out_ready_i| event_key_o, event_kind_o, hold_ticks_o
//
// A sample is taken into an input register, its key entry is read, updated and
// written back, and any event lands in the output register: one sample per
// cycle, unless a stalled output holds back a sample that produces an event.
// Reset clears all key entries at once; no sweep is needed.
// A stalled output holds only samples that produce an event; others still flow.
`timescale 1ns / 1ps

module key_press_hold_release_events_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kphr_pkg::KeyW-1:0]     key_index_i,
  input  logic                          pressed_i,
  input  logic                          stop_keep_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kphr_pkg::KeyW-1:0]     event_key_o,
  output logic [kphr_pkg::KindW-1:0]    event_kind_o,
  output logic [kphr_pkg::CountW-1:0]   hold_ticks_o
);
  import kphr_pkg::*;

  logic       req_valid_q;
  key_req_t   req_q;
  key_event_t ev;
  logic       advance;
  logic       out_valid_q;
  key_event_t out_q;

  // The sample moves on when it has no event or the output slot is free.
  assign advance    = req_valid_q & (~ev.valid | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~req_valid_q | advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.key     <= key_index_i;
      req_q.pressed <= pressed_i;
      req_q.stop    <= stop_keep_i;
    end
  end

  kphr_keytable u_keytable (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .commit_i (advance),
    .event_o  (ev)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && ev.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev.valid) begin
      out_q <= ev;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_key_o  = out_q.key;
  assign event_kind_o = out_q.kind;
  assign hold_ticks_o = out_q.ticks;

endmodule

### rtl/kphr_checker.sv
// Port-level checks for the key press / hold / release event detector.
// Depends on kphr_pkg; bound to key_press_hold_release_events_top below.
`timescale 1ns / 1ps

module kphr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [kphr_pkg::KeyW-1:0]     event_key_o,
  input logic [kphr_pkg::KindW-1:0]    event_kind_o,
  input logic [kphr_pkg::CountW-1:0]   hold_ticks_o
);
  import kphr_pkg::*;

  // A pending event is not withdrawn before its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("event dropped before transfer");

  // A pending event keeps its payload until its transfer.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(event_key_o) && $stable(event_kind_o) &&
                                    $stable(hold_ticks_o))
    else $error("event payload changed before transfer");

  // Only the three event codes ever leave the block.
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o == KIND_BEGIN || event_kind_o == KIND_KEEP ||
                     event_kind_o == KIND_END))
    else $error("unknown event kind");

  // A press begin always reports a zero hold count.
  a_begin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_BEGIN |-> hold_ticks_o == '0)
    else $error("begin event with nonzero count");

  // With the output slot empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind key_press_hold_release_events_top kphr_checker u_kphr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_key_o  (event_key_o),
  .event_kind_o (event_kind_o),
  .hold_ticks_o (hold_ticks_o)
);

### dv/tb_key_press_hold_release_events_top.sv
// Self-checking testbench for key_press_hold_release_events_top.
// Drives key samples over a valid/ready channel, predicts begin/keep/end events
// per key, and checks every output transfer. Depends on kphr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_key_press_hold_release_events_top;
  import kphr_pkg::*;

  localparam int IdleLimit  = 1000;
  localparam int RandItems  = 450;
  localparam int DirRows    = 25;
  localparam int TailCycles = 10;

  // One row of the directed sequence; want is used only when typed is set.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            pressed;
    logic            stop;
    logic            typed;
    key_event_t      want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready_o;
  logic [KeyW-1:0]   key_index;
  logic              pressed;
  logic              stop_keep;
  logic              out_valid_o;
  logic              out_ready;
  logic [KeyW-1:0]   event_key_o;
  logic [KindW-1:0]  event_kind_o;
  logic [CountW-1:0] hold_ticks_o;

  // Predicted per-key state: level, keep permission and tick counter.
  logic              key_down   [KEYS];
  logic              keep_armed [KEYS];
  logic [CountW-1:0] tick_count [KEYS];

  key_event_t pending_events [$];
  dir_row_t   dir_rows [DirRows];
  int         n_mismatch;
  int         idle_cycles;
  int         n_sent;
  bit         tx_steady;

  key_press_hold_release_events_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .key_index_i  (key_index),
    .pressed_i    (pressed),
    .stop_keep_i  (stop_keep),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .event_key_o  (event_key_o),
    .event_kind_o (event_kind_o),
    .hold_ticks_o (hold_ticks_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Updates the predicted key entry for one sample and returns its event, if any.
  function automatic key_event_t predict_key_event(input logic [KeyW-1:0] k,
                                                   input logic p, input logic s);
    key_event_t ev;
    ev = '0;
    if (int'(k) >= KEYS) begin
      return ev;
    end
    if (p != key_down[k]) begin
      key_down[k] = p;
      if (p) begin
        tick_count[k] = '0;
        keep_armed[k] = !s;
        ev = '{1'b1, k, KIND_BEGIN, 8'd0};
      end else begin
        tick_count[k] = tick_count[k] + 1'b1;
        ev = '{1'b1, k, KIND_END, tick_count[k]};
      end
    end else if (p) begin
      tick_count[k] = tick_count[k] + 1'b1;
      if (keep_armed[k]) begin
        ev = '{1'b1, k, KIND_KEEP, tick_count[k]};
        if (s) begin
          keep_armed[k] = 1'b0;
        end
      end
    end
    return ev;
  endfunction

  function automatic dir_row_t mk_row(input int k, input logic p, input logic s,
                                      input logic typed, input logic has_ev,
                                      input kind_e kind, input int ticks);
    dir_row_t r;
    r.key     = k[KeyW-1:0];
    r.pressed = p;
    r.stop    = s;
    r.typed   = typed;
    r.want    = '{has_ev, k[KeyW-1:0], kind, ticks[CountW-1:0]};
    return r;
  endfunction

  // Sender gap: mostly none or short, now and then long; some stretches run flat out.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) begin
      tx_steady = !tx_steady;
    end
    if (tx_steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(15, 40);
  endfunction

  // Presents one sample, waits for its transfer and records the expected event.
  task automatic send_sample(input logic [KeyW-1:0] k, input logic p, input logic s,
                             input logic typed, input key_event_t want);
    key_event_t ev;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    key_index <= k;
    pressed   <= p;
    stop_keep <= s;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    ev = predict_key_event(k, p, s);
    if (typed) begin
      ev = want;
    end
    if (ev.valid) begin
      pending_events.push_back(ev);
    end
    n_sent++;
  endtask

  task automatic send_rand(input logic [KeyW-1:0] k, input logic p, input logic s);
    send_sample(k, p, s, 1'b0, '0);
  endtask

  // Holds the sender off until every expected event has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, short and long, with stall-free stretches.
  initial begin : rx_side
    int stall;
    int quiet;
    int r;
    out_ready = 1'b0;
    stall = 0;
    quiet = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (quiet > 0) begin
          quiet--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            quiet = $urandom_range(20, 80);
          end else if (r < 40) begin
            stall = $urandom_range(1, 3);
          end else if (r < 44) begin
            stall = $urandom_range(10, 40);
          end
        end
      end
    end
  end

  // Output checker and idle-cycle counter, both sampled at the rising edge.
  always @(posedge clk) begin : out_check
    key_event_t head;
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_valid_o !== 1'b0 && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, got key %0d kind %0d ticks %0d",
                 $time, event_key_o, event_kind_o, hold_ticks_o);
        n_mismatch++;
      end else begin
        head = pending_events.pop_front();
        if (out_valid_o !== 1'b1) begin
          $display("%0t: out_valid: expected 1, got %b", $time, out_valid_o);
          n_mismatch++;
        end
        if (event_key_o !== head.key) begin
          $display("%0t: event_key: expected %0d, got %0d", $time, head.key, event_key_o);
          n_mismatch++;
        end
        if (event_kind_o !== head.kind) begin
          $display("%0t: event_kind: expected %0d, got %0d", $time, head.kind,
                   event_kind_o);
          n_mismatch++;
        end
        if (hold_ticks_o !== head.ticks) begin
          $display("%0t: hold_ticks: expected %0d, got %0d", $time, head.ticks,
                   hold_ticks_o);
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer has happened for too long.
  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [KeyW-1:0] k;
    int hold_len;
    bit long_done;
    bit mid_drain;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    key_index   = '0;
    pressed     = 1'b0;
    stop_keep   = 1'b0;
    n_mismatch  = 0;
    idle_cycles = 0;
    n_sent      = 0;
    tx_steady   = 1'b0;
    long_done   = 1'b0;
    mid_drain   = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      key_down[i]   = 1'b0;
      keep_armed[i] = 1'b0;
      tick_count[i] = '0;
    end

    // Directed rows: release after reset, keep and stop, rising edge with stop,
    // stop ignored on release, interleaved keys, re-press clearing the count.
    dir_rows[0]  = mk_row(0,  1'b0, 1'b0, 1'b1, 1'b0, KIND_BEGIN, 0);
    dir_rows[1]  = mk_row(0,  1'b1, 1'b0, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[2]  = mk_row(0,  1'b1, 1'b0, 1'b1, 1'b1, KIND_KEEP,  1);
    dir_rows[3]  = mk_row(0,  1'b1, 1'b1, 1'b1, 1'b1, KIND_KEEP,  2);
    dir_rows[4]  = mk_row(0,  1'b1, 1'b0, 1'b1, 1'b0, KIND_BEGIN, 0);
    dir_rows[5]  = mk_row(0,  1'b0, 1'b1, 1'b1, 1'b1, KIND_END,   4);
    dir_rows[6]  = mk_row(15, 1'b1, 1'b1, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[7]  = mk_row(15, 1'b1, 1'b0, 1'b1, 1'b0, KIND_BEGIN, 0);
    dir_rows[8]  = mk_row(15, 1'b0, 1'b0, 1'b1, 1'b1, KIND_END,   2);
    dir_rows[9]  = mk_row(15, 1'b0, 1'b1, 1'b1, 1'b0, KIND_BEGIN, 0);
    dir_rows[10] = mk_row(5,  1'b1, 1'b0, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[11] = mk_row(10, 1'b1, 1'b0, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[12] = mk_row(5,  1'b1, 1'b0, 1'b1, 1'b1, KIND_KEEP,  1);
    dir_rows[13] = mk_row(10, 1'b1, 1'b1, 1'b1, 1'b1, KIND_KEEP,  1);
    dir_rows[14] = mk_row(10, 1'b1, 1'b0, 1'b1, 1'b0, KIND_BEGIN, 0);
    dir_rows[15] = mk_row(5,  1'b0, 1'b0, 1'b1, 1'b1, KIND_END,   2);
    dir_rows[16] = mk_row(10, 1'b0, 1'b0, 1'b1, 1'b1, KIND_END,   3);
    dir_rows[17] = mk_row(5,  1'b1, 1'b1, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[18] = mk_row(5,  1'b0, 1'b0, 1'b1, 1'b1, KIND_END,   1);
    dir_rows[19] = mk_row(0,  1'b1, 1'b0, 1'b1, 1'b1, KIND_BEGIN, 0);
    dir_rows[20] = mk_row(0,  1'b1, 1'b0, 1'b1, 1'b1, KIND_KEEP,  1);
    dir_rows[21] = mk_row(0,  1'b0, 1'b0, 1'b1, 1'b1, KIND_END,   2);
    dir_rows[22] = mk_row(3,  1'b1, 1'b0, 1'b0, 1'b0, KIND_BEGIN, 0);
    dir_rows[23] = mk_row(12, 1'b1, 1'b1, 1'b0, 1'b0, KIND_BEGIN, 0);
    dir_rows[24] = mk_row(3,  1'b0, 1'b1, 1'b0, 1'b0, KIND_BEGIN, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      send_sample(dir_rows[i].key, dir_rows[i].pressed, dir_rows[i].stop,
                  dir_rows[i].typed, dir_rows[i].want);
    end
    wait_for_drain();

    // Random part: mostly press/hold/release sequences, plus one hold long enough
    // to wrap the counter, and loose samples as noise.
    n_sent = 0;
    while (n_sent < RandItems) begin
      k = KeyW'($urandom_range(0, KEYS - 1));
      if (!long_done && n_sent >= 150) begin
        send_rand(k, 1'b1, 1'b0);
        repeat ($urandom_range(256, 270)) send_rand(k, 1'b1, 1'b0);
        send_rand(k, 1'b0, 1'($urandom_range(0, 1)));
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        send_rand(k, 1'b1, $urandom_range(0, 3) == 0);
        hold_len = $urandom_range(0, 12);
        for (int h = 0; h < hold_len; h++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_rand(KeyW'($urandom_range(0, KEYS - 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
          send_rand(k, 1'b1, $urandom_range(0, 5) == 0);
        end
        send_rand(k, 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        send_rand(k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if (!mid_drain && n_sent >= 80) begin
        wait_for_drain();
        mid_drain = 1'b1;
      end
    end

    wait_for_drain();
    repeat (TailCycles) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
